/* hw/rtl/multi_channel_ultrasonic_ranger_macros.svh */
// Assertion macros used by the ranger sequencer RTL.
`ifndef MULTI_CHANNEL_ULTRASONIC_RANGER_MACROS_SVH
`define MULTI_CHANNEL_ULTRASONIC_RANGER_MACROS_SVH

// Same-cycle implication.
`define MCUR_ASSERT_IMP(name, clk, rst, ante, cons) \
  name: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) \
    else $error("mcur: same-cycle check failed");

// Next-cycle implication.
`define MCUR_ASSERT_NEXT(name, clk, rst, ante, cons) \
  name: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) \
    else $error("mcur: next-cycle check failed");

`endif

/* hw/rtl/mcur_pkg.sv */
// Types and constants of the ultrasonic ranger.
package mcur_pkg;

  // Sensor field is 3 bits, so at most eight channels.
  localparam int SENSOR_COUNT = 8;
  localparam int CH_W = (SENSOR_COUNT > 1) ? $clog2(SENSOR_COUNT) : 1;

  localparam int CFG_IDX_W  = 3;
  localparam int CFG_DATA_W = 24;
  localparam int PERIOD_W   = 17;
  localparam int TRIG_W     = 8;
  localparam int TICKS_W    = 24;
  localparam int DIST_W     = 16;
  localparam int PROD_W     = TICKS_W + PERIOD_W;

  localparam logic [TICKS_W-1:0] TICK_MAX = '1;
  localparam logic [DIST_W-1:0]  DIST_SAT = '1;
  localparam logic [DIST_W-1:0]  MIN_KEEP = DIST_W'(200);

  // ticks*period / 580: saturate at or above 65536*580, else drop two bits and
  // multiply by ceil(2^39/145), exact for the 24-bit remainder range.
  localparam logic [PROD_W-1:0] SAT_LIMIT = PROD_W'(38010880);
  localparam int QX_LO       = 2;
  localparam int QX_W        = 24;
  localparam int RECIP_W     = 32;
  localparam int RECIP_SHIFT = 39;
  localparam logic [RECIP_W-1:0] RECIP_M = 32'd3791419407;

  localparam logic [PERIOD_W-1:0] PERIOD_RST  = PERIOD_W'(10000);
  localparam logic [TRIG_W-1:0]   TRIG_RST    = TRIG_W'(1);
  localparam logic [TICKS_W-1:0]  TIMEOUT_RST = TICKS_W'(1800);
  localparam logic [DIST_W-1:0]   MAXDIST_RST = DIST_W'(20000);

  typedef enum logic [1:0] {
    OP_TICK    = 2'd0,
    OP_TRIGGER = 2'd1,
    OP_ECHO    = 2'd2,
    OP_READ    = 2'd3
  } op_t;

  typedef enum logic [CFG_IDX_W-1:0] {
    REG_ENABLE  = 3'd0,
    REG_PERIOD  = 3'd1,
    REG_TRIG    = 3'd2,
    REG_TIMEOUT = 3'd3,
    REG_MAXDIST = 3'd4
  } cfg_reg_t;

  typedef enum logic [2:0] {
    DP_NOP,
    DP_TICK,
    DP_MUL,
    DP_DIV,
    DP_SINGLE
  } dp_op_t;

  typedef enum logic [2:0] {
    S_IDLE,
    S_TICK,
    S_MUL,
    S_DIV,
    S_SINGLE
  } state_t;

  typedef struct packed {
    logic            load;
    dp_op_t          op;
    logic [CH_W-1:0] chan;
    logic            commit;
  } cmd_t;

  typedef struct packed {
    logic emit_req;
    logic out_free;
  } stat_t;

endpackage

/* hw/rtl/mcur_cmd_if.sv */
// Input channel: one operation word per handshake.
interface mcur_cmd_if;
  logic       valid;
  logic       ready;
  logic [1:0] operation;
  logic [2:0] sensor;
  logic       echo_level;

  modport source (output valid, output operation, output sensor, output echo_level,
                  input ready);
  modport sink (input valid, input operation, input sensor, input echo_level,
                output ready);
endinterface

/* hw/rtl/mcur_rsp_if.sv */
// Result channel: one per-sensor result word per handshake.
interface mcur_rsp_if;
  logic        valid;
  logic        ready;
  logic [2:0]  sensor_id;
  logic        pin_fell;
  logic        pin_rose;
  logic        ready_res;
  logic [15:0] distance;
  logic        last;

  modport source (output valid, output sensor_id, output pin_fell, output pin_rose,
                  output ready_res, output distance, output last, input ready);
  modport sink (input valid, input sensor_id, input pin_fell, input pin_rose,
                input ready_res, input distance, input last, output ready);
endinterface

/* hw/rtl/multi_channel_ultrasonic_ranger.sv */
// Top level of the multi-channel ultrasonic ranger.
//
//   port   dir     word                                        handshake
//   cmd    in      operation, sensor, echo_level               valid/ready
//   rsp    out     sensor_id, pin_fell, pin_rose, ready_res,   valid/ready
//                  distance, last
//   cfg_*  in      cfg_index, cfg_data                         cfg_write strobe
//
// On a tick the sequencer visits one channel per cycle while no stall holds it.
// Trigger, read and rising echo are committed directly; a falling echo first passes
// the registered multiply and reciprocal-multiply stages of the conversion.
// Reset is synchronous; channel state clears at once, no sweep.
// A full result register stalls the walk at a channel that has a result to emit;
// a new word is taken while a result still waits.
module multi_channel_ultrasonic_ranger import mcur_pkg::*; (
  input  logic                  clk,
  input  logic                  rst,
  mcur_cmd_if.sink              cmd,
  mcur_rsp_if.source            rsp,
  input  logic                  cfg_write,
  input  logic [CFG_IDX_W-1:0]  cfg_index,
  input  logic [CFG_DATA_W-1:0] cfg_data
);

  cmd_t  ctl;
  stat_t stat;

  mcur_ctrl u_ctrl (
    .clk      (clk),
    .rst      (rst),
    .in_valid (cmd.valid),
    .in_op    (cmd.operation),
    .in_level (cmd.echo_level),
    .in_ready (cmd.ready),
    .ctl      (ctl),
    .stat     (stat)
  );

  mcur_dp u_dp (
    .clk        (clk),
    .rst        (rst),
    .cfg_write  (cfg_write),
    .cfg_index  (cfg_index),
    .cfg_data   (cfg_data),
    .operation  (cmd.operation),
    .sensor     (cmd.sensor),
    .echo_level (cmd.echo_level),
    .ctl        (ctl),
    .stat       (stat),
    .rsp        (rsp)
  );

endmodule

/* hw/rtl/mcur_ctrl.sv */
// Sequencer: walks channels on a tick and steps the echo conversion.
`include "multi_channel_ultrasonic_ranger_macros.svh"

module mcur_ctrl import mcur_pkg::*; (
  input  logic       clk,
  input  logic       rst,
  input  logic       in_valid,
  input  logic [1:0] in_op,
  input  logic       in_level,
  output logic       in_ready,
  output cmd_t       ctl,
  input  stat_t      stat
);

  state_t          state, state_next;
  logic [CH_W-1:0] cnt, cnt_next;
  logic            commit_ok;
  logic            accept;
  logic            last_ch;

  assign commit_ok = stat.out_free || !stat.emit_req;
  assign accept    = in_valid && (state == S_IDLE);
  assign last_ch   = (cnt == CH_W'(SENSOR_COUNT - 1));

  always_ff @(posedge clk) begin
    if (rst) begin
      state <= S_IDLE;
      cnt   <= '0;
    end else begin
      state <= state_next;
      cnt   <= cnt_next;
    end
  end

  always_comb begin
    state_next = state;
    cnt_next   = cnt;
    unique case (state)
      S_IDLE: begin
        cnt_next = '0;
        if (accept) begin
          if (in_op == OP_TICK) begin
            state_next = S_TICK;
          end else if (in_op == OP_ECHO && !in_level) begin
            state_next = S_MUL;
          end else begin
            state_next = S_SINGLE;
          end
        end
      end
      S_TICK: begin
        if (commit_ok) begin
          cnt_next = cnt + CH_W'(1);
          if (last_ch) begin
            state_next = S_IDLE;
          end
        end
      end
      S_MUL:    state_next = S_DIV;
      S_DIV:    state_next = S_SINGLE;
      S_SINGLE: begin
        if (commit_ok) begin
          state_next = S_IDLE;
        end
      end
      default:  state_next = S_IDLE;
    endcase
  end

  always_comb begin
    in_ready   = 1'b0;
    ctl.load   = 1'b0;
    ctl.op     = DP_NOP;
    ctl.chan   = cnt;
    ctl.commit = 1'b0;
    unique case (state)
      S_IDLE: begin
        in_ready = 1'b1;
        ctl.load = in_valid;
      end
      S_TICK: begin
        ctl.op     = DP_TICK;
        ctl.commit = commit_ok;
      end
      S_MUL:    ctl.op = DP_MUL;
      S_DIV:    ctl.op = DP_DIV;
      S_SINGLE: begin
        ctl.op     = DP_SINGLE;
        ctl.commit = commit_ok;
      end
      default: ;
    endcase
  end

  `MCUR_ASSERT_NEXT(a_mul_then_div, clk, rst, state == S_MUL, state == S_DIV)
  `MCUR_ASSERT_IMP(a_emit_has_room, clk, rst, ctl.commit && stat.emit_req, stat.out_free)
  `MCUR_ASSERT_NEXT(a_tick_starts_at_zero, clk, rst, accept && in_op == OP_TICK, state == S_TICK && cnt == '0)
  `MCUR_ASSERT_NEXT(a_stalled_tick_holds, clk, rst, state == S_TICK && !ctl.commit, state == S_TICK && $stable(cnt))

endmodule

/* hw/rtl/mcur_dp.sv */
// Channel state, config registers, distance conversion and result register.
module mcur_dp import mcur_pkg::*; (
  input  logic                  clk,
  input  logic                  rst,
  input  logic                  cfg_write,
  input  logic [CFG_IDX_W-1:0]  cfg_index,
  input  logic [CFG_DATA_W-1:0] cfg_data,
  input  logic [1:0]            operation,
  input  logic [2:0]            sensor,
  input  logic                  echo_level,
  input  cmd_t                  ctl,
  output stat_t                 stat,
  mcur_rsp_if.source            rsp
);

  logic [SENSOR_COUNT-1:0] sensor_enable;
  logic [PERIOD_W-1:0]     tick_period_ns;
  logic [TRIG_W-1:0]       trigger_ticks;
  logic [TICKS_W-1:0]      echo_timeout_ticks;
  logic [DIST_W-1:0]       max_distance;

  logic [TICKS_W-1:0] echo_ticks    [SENSOR_COUNT];
  logic [TRIG_W-1:0]  trigger_left  [SENSOR_COUNT];
  logic [TICKS_W-1:0] timeout_left  [SENSOR_COUNT];
  logic               edge_seen     [SENSOR_COUNT];
  logic [DIST_W-1:0]  last_distance [SENSOR_COUNT];

  logic [1:0]  item_op;
  logic [2:0]  item_sensor;
  logic        item_level;

  logic [PROD_W-1:0] prod;
  logic [DIST_W-1:0] dist_q;
  logic              keep_q;

  logic                    out_valid;
  logic [2:0]              out_id;
  logic                    out_fell, out_rose, out_rdy, out_last;
  logic [DIST_W-1:0]       out_dist;

  // tick evaluation, all channels side by side
  logic [TICKS_W-1:0]      tl_arm [SENSOR_COUNT];
  logic [SENSOR_COUNT-1:0] evt;
  logic                    later_evt;

  logic [CH_W-1:0]   c;
  logic              c_fell, c_rose;
  logic [TICKS_W-1:0] c_et_inc, c_tl_dec;
  logic [TRIG_W-1:0]  c_tr_dec;

  logic [CH_W-1:0]   s;
  logic              bad;
  logic              fall_keep;
  logic              emit;

  logic [QX_W+RECIP_W-1:0] recip;
  logic [DIST_W-1:0]       quot;

  always_comb begin
    for (int j = 0; j < SENSOR_COUNT; j++) begin
      tl_arm[j] = (trigger_left[j] == TRIG_W'(1)) ? echo_timeout_ticks : timeout_left[j];
      evt[j]    = sensor_enable[j] &&
                  (trigger_left[j] == TRIG_W'(1) || tl_arm[j] == TICKS_W'(1));
    end
  end

  assign c = ctl.chan;

  always_comb begin
    later_evt = 1'b0;
    for (int j = 0; j < SENSOR_COUNT; j++) begin
      if (CH_W'(j) > c && evt[j]) begin
        later_evt = 1'b1;
      end
    end
  end

  assign c_fell   = (trigger_left[c] == TRIG_W'(1));
  assign c_rose   = (tl_arm[c] == TICKS_W'(1));
  assign c_et_inc = (echo_ticks[c] < TICK_MAX) ? echo_ticks[c] + TICKS_W'(1) : echo_ticks[c];
  assign c_tr_dec = (trigger_left[c] != '0) ? trigger_left[c] - TRIG_W'(1) : trigger_left[c];
  assign c_tl_dec = (tl_arm[c] != '0) ? tl_arm[c] - TICKS_W'(1) : tl_arm[c];

  assign s         = item_sensor[CH_W-1:0];
  assign bad       = (int'(item_sensor) >= SENSOR_COUNT);
  assign fall_keep = edge_seen[s] && (echo_ticks[s] != '0) && keep_q;

  assign stat.emit_req = (ctl.op == DP_TICK) ? evt[c] : (ctl.op == DP_SINGLE);
  assign stat.out_free = !out_valid || rsp.ready;
  assign emit          = ctl.commit && stat.emit_req;

  assign recip = (QX_W+RECIP_W)'(prod[QX_LO+QX_W-1:QX_LO]) * (QX_W+RECIP_W)'(RECIP_M);
  assign quot  = recip[RECIP_SHIFT+DIST_W-1:RECIP_SHIFT];

  // latched item and conversion pipeline
  always_ff @(posedge clk) begin
    if (ctl.load) begin
      item_op     <= operation;
      item_sensor <= sensor;
      item_level  <= echo_level;
    end
    if (ctl.op == DP_MUL) begin
      prod <= PROD_W'(echo_ticks[s]) * PROD_W'(tick_period_ns);
    end
    if (ctl.op == DP_DIV) begin
      if (prod >= SAT_LIMIT) begin
        dist_q <= DIST_SAT;
        keep_q <= 1'b1;
      end else begin
        dist_q <= quot;
        keep_q <= (quot > MIN_KEEP);
      end
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      sensor_enable      <= '0;
      tick_period_ns     <= PERIOD_RST;
      trigger_ticks      <= TRIG_RST;
      echo_timeout_ticks <= TIMEOUT_RST;
      max_distance       <= MAXDIST_RST;
      for (int i = 0; i < SENSOR_COUNT; i++) begin
        echo_ticks[i]    <= '0;
        trigger_left[i]  <= '0;
        timeout_left[i]  <= '0;
        edge_seen[i]     <= 1'b0;
        last_distance[i] <= '0;
      end
    end else begin
      if (ctl.commit && ctl.op == DP_TICK && sensor_enable[c]) begin
        if (c_rose) begin
          // timeout: report max distance and retrigger for one tick
          last_distance[c] <= max_distance;
          echo_ticks[c]    <= '0;
          edge_seen[c]     <= 1'b0;
          trigger_left[c]  <= TRIG_W'(1);
          timeout_left[c]  <= '0;
        end else begin
          echo_ticks[c]   <= c_et_inc;
          trigger_left[c] <= c_tr_dec;
          timeout_left[c] <= c_tl_dec;
        end
      end
      if (ctl.commit && ctl.op == DP_SINGLE && !bad) begin
        case (op_t'(item_op))
          OP_TRIGGER: begin
            timeout_left[s] <= '0;
            trigger_left[s] <= trigger_ticks;
            edge_seen[s]    <= 1'b0;
          end
          OP_ECHO: begin
            if (item_level) begin
              echo_ticks[s] <= '0;
              edge_seen[s]  <= 1'b1;
            end else if (edge_seen[s]) begin
              edge_seen[s] <= 1'b0;
              if (fall_keep) begin
                last_distance[s] <= dist_q;
                timeout_left[s]  <= '0;
              end
            end
          end
          default: ;
        endcase
      end
      if (cfg_write) begin
        unique case (cfg_index)
          REG_ENABLE: begin
            for (int i = 0; i < SENSOR_COUNT; i++) begin
              // newly enabled channel starts clean
              if (cfg_data[i] && !sensor_enable[i]) begin
                echo_ticks[i]    <= '0;
                trigger_left[i]  <= '0;
                timeout_left[i]  <= '0;
                edge_seen[i]     <= 1'b0;
                last_distance[i] <= '0;
              end
            end
            sensor_enable <= cfg_data[SENSOR_COUNT-1:0];
          end
          REG_PERIOD:  tick_period_ns     <= cfg_data[PERIOD_W-1:0];
          REG_TRIG:    trigger_ticks      <= cfg_data[TRIG_W-1:0];
          REG_TIMEOUT: echo_timeout_ticks <= cfg_data[TICKS_W-1:0];
          REG_MAXDIST: max_distance       <= cfg_data[DIST_W-1:0];
          default: ;
        endcase
      end
    end
  end

  // result register
  always_ff @(posedge clk) begin
    if (rst) begin
      out_valid <= 1'b0;
    end else if (emit) begin
      out_valid <= 1'b1;
    end else if (rsp.ready) begin
      out_valid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (emit) begin
      if (ctl.op == DP_TICK) begin
        out_id   <= 3'(c);
        out_fell <= c_fell;
        out_rose <= c_rose;
        out_rdy  <= c_rose;
        out_dist <= c_rose ? max_distance : last_distance[c];
        out_last <= !later_evt;
      end else begin
        out_id   <= item_sensor;
        out_fell <= 1'b0;
        out_rose <= !bad && (item_op == OP_TRIGGER);
        out_last <= 1'b1;
        if (bad) begin
          out_rdy  <= 1'b0;
          out_dist <= '0;
        end else if (item_op == OP_ECHO && !item_level && fall_keep) begin
          out_rdy  <= 1'b1;
          out_dist <= dist_q;
        end else begin
          out_rdy  <= 1'b0;
          out_dist <= last_distance[s];
        end
      end
    end
  end

  assign rsp.valid     = out_valid;
  assign rsp.sensor_id = out_id;
  assign rsp.pin_fell  = out_fell;
  assign rsp.pin_rose  = out_rose;
  assign rsp.ready_res = out_rdy;
  assign rsp.distance  = out_dist;
  assign rsp.last      = out_last;

endmodule

/* verif/multi_channel_ultrasonic_ranger_tb.sv */
// Self-checking testbench: random and directed operation words, results predicted per channel.
module multi_channel_ultrasonic_ranger_tb import mcur_pkg::*; ;
  timeunit 1ns;
  timeprecision 1ps;

  localparam int          RANDOM_WORDS  = 80;
  localparam int          MAX_GAP       = 19;
  localparam int          SETTLE_CYCLES = 24;
  localparam int          LONG_HOLD     = 300;
  localparam int          SAT_TICKS     = 300;
  localparam int          CYCLE_LIMIT   = 1000000;
  localparam int          REPORT_CAP    = 100;
  localparam int unsigned CONV_DIVISOR  = 580;

  typedef struct packed {
    op_t             op;
    logic [CH_W-1:0] sensor;
    logic            level;
  } command_t;

  typedef struct packed {
    logic [CH_W-1:0]   sensor_id;
    logic              pin_fell;
    logic              pin_rose;
    logic              ready_res;
    logic [DIST_W-1:0] distance;
    logic              last;
  } reading_t;

  logic                  clk;
  logic                  rst;
  logic                  cfg_write;
  logic [CFG_IDX_W-1:0]  cfg_index;
  logic [CFG_DATA_W-1:0] cfg_data;

  mcur_cmd_if cmd_bus ();
  mcur_rsp_if rsp_bus ();

  multi_channel_ultrasonic_ranger DUT (
    .clk       (clk),
    .rst       (rst),
    .cmd       (cmd_bus),
    .rsp       (rsp_bus),
    .cfg_write (cfg_write),
    .cfg_index (cfg_index),
    .cfg_data  (cfg_data)
  );

  // Predicted configuration and per-channel state.
  logic [SENSOR_COUNT-1:0] cfg_enable  = '0;
  logic [PERIOD_W-1:0]     cfg_period  = PERIOD_RST;
  logic [TRIG_W-1:0]       cfg_trig    = TRIG_RST;
  logic [TICKS_W-1:0]      cfg_timeout = TIMEOUT_RST;
  logic [DIST_W-1:0]       cfg_maxdist = MAXDIST_RST;

  logic [TICKS_W-1:0] echo_count [SENSOR_COUNT] = '{default: '0};
  logic [TRIG_W-1:0]  trig_left  [SENSOR_COUNT] = '{default: '0};
  logic [TICKS_W-1:0] wait_left  [SENSOR_COUNT] = '{default: '0};
  logic               edge_armed [SENSOR_COUNT] = '{default: 1'b0};
  logic [DIST_W-1:0]  range_held [SENSOR_COUNT] = '{default: '0};

  command_t pending_words [$];
  reading_t expected_readings [$];

  int unsigned words_queued  = 0;
  int unsigned words_taken   = 0;
  int unsigned mismatches    = 0;
  int unsigned cycle_count   = 0;
  int unsigned long_hold_req = 0;
  bit          send_idle     = 1'b0;
  bit          recv_idle     = 1'b0;
  int unsigned send_gap;
  int unsigned recv_gap;
  int unsigned hold_left;
  command_t    offered;
  reading_t    seen;
  reading_t    want;

  task automatic report(string what);
    mismatches++;
    if (mismatches <= REPORT_CAP) $display("[%0t] mismatch: %s", $realtime, what);
  endtask

  // Updates channel state for one accepted word and queues the results it causes.
  function automatic void advance_ranger(command_t c);
    reading_t          r;
    reading_t          batch [$];
    longint unsigned   span;
    int unsigned       s;
    s = 32'(c.sensor);
    if (c.op == OP_TICK) begin
      for (int i = 0; i < SENSOR_COUNT; i++) begin
        if (!cfg_enable[i]) continue;
        r = '0;
        r.sensor_id = CH_W'(i);
        if (echo_count[i] != TICK_MAX) echo_count[i]++;
        if (trig_left[i] != 0) begin
          trig_left[i]--;
          if (trig_left[i] == 0) begin
            r.pin_fell = 1'b1;
            wait_left[i] = cfg_timeout;
          end
        end
        // fall and timeout can land on the same tick
        if (wait_left[i] != 0) begin
          wait_left[i]--;
          if (wait_left[i] == 0) begin
            range_held[i] = cfg_maxdist;
            echo_count[i] = '0;
            edge_armed[i] = 1'b0;
            trig_left[i]  = TRIG_W'(1);
            r.pin_rose    = 1'b1;
            r.ready_res   = 1'b1;
          end
        end
        if (r.pin_fell || r.pin_rose) begin
          r.distance = range_held[i];
          batch.push_back(r);
        end
      end
      if (batch.size() != 0) batch[batch.size() - 1].last = 1'b1;
      foreach (batch[k]) expected_readings.push_back(batch[k]);
      return;
    end
    r = '0;
    r.sensor_id = c.sensor;
    r.last = 1'b1;
    if (s < SENSOR_COUNT) begin
      case (c.op)
        OP_TRIGGER: begin
          wait_left[s]  = '0;
          trig_left[s]  = cfg_trig;
          edge_armed[s] = 1'b0;
          r.pin_rose    = 1'b1;
        end
        OP_ECHO: begin
          if (c.level) begin
            echo_count[s] = '0;
            edge_armed[s] = 1'b1;
          end else if (edge_armed[s]) begin
            edge_armed[s] = 1'b0;
            if (echo_count[s] != 0) begin
              span = longint'(echo_count[s]) * longint'(cfg_period) / CONV_DIVISOR;
              if (span > MIN_KEEP) begin
                range_held[s] = (span > DIST_SAT) ? DIST_SAT : DIST_W'(span);
                wait_left[s]  = '0;
                r.ready_res   = 1'b1;
              end
            end
          end
        end
        default: ;
      endcase
      r.distance = range_held[s];
    end
    expected_readings.push_back(r);
  endfunction

  task automatic write_reg(logic [CFG_IDX_W-1:0] idx, int unsigned value);
    logic [CFG_DATA_W-1:0] keep;
    logic [CFG_DATA_W-1:0] data;
    case (idx)
      REG_ENABLE, REG_TRIG: keep = CFG_DATA_W'(8'hFF);
      REG_PERIOD:           keep = CFG_DATA_W'(17'h1FFFF);
      REG_TIMEOUT:          keep = '1;
      REG_MAXDIST:          keep = CFG_DATA_W'(16'hFFFF);
      default:              keep = '0;
    endcase
    // bits above the field carry noise that the block has to drop
    data = (CFG_DATA_W'(value) & keep) | (CFG_DATA_W'($urandom) & ~keep);
    @(posedge clk);
    cfg_write <= 1'b1;
    cfg_index <= idx;
    cfg_data  <= data;
    case (idx)
      REG_ENABLE: begin
        for (int i = 0; i < SENSOR_COUNT; i++) begin
          if (data[i] && !cfg_enable[i]) begin
            echo_count[i] = '0;
            trig_left[i]  = '0;
            wait_left[i]  = '0;
            edge_armed[i] = 1'b0;
            range_held[i] = '0;
          end
        end
        cfg_enable = data[SENSOR_COUNT-1:0];
      end
      REG_PERIOD:  cfg_period  = data[PERIOD_W-1:0];
      REG_TRIG:    cfg_trig    = data[TRIG_W-1:0];
      REG_TIMEOUT: cfg_timeout = data[TICKS_W-1:0];
      REG_MAXDIST: cfg_maxdist = data[DIST_W-1:0];
      default: ;
    endcase
    @(posedge clk);
    cfg_write <= 1'b0;
  endtask

  task automatic queue_op(op_t op, int unsigned s, int unsigned level);
    pending_words.push_back('{op: op, sensor: CH_W'(s), level: 1'(level)});
    words_queued++;
  endtask

  task automatic queue_ticks(int unsigned n);
    repeat (n) queue_op(OP_TICK, $urandom_range(0, 7), $urandom_range(0, 1));
  endtask

  // Waits until every word is taken and answered, then lets a silent tick walk finish.
  task automatic wait_idle();
    while (words_taken != words_queued || expected_readings.size() != 0) @(posedge clk);
    repeat (SETTLE_CYCLES) @(posedge clk);
  endtask

  initial begin
    clk = 1'b0;
    forever #1 clk = ~clk;
  end

  always @(posedge clk) begin
    cycle_count++;
    if (cycle_count > CYCLE_LIMIT) begin
      $display("** multi_channel_ultrasonic_ranger: FAILED **");
      $finish;
    end
  end

  // Command driver.
  always @(posedge clk) begin
    if (rst) begin
      cmd_bus.valid <= 1'b0;
      send_gap = 0;
    end else begin
      if (cmd_bus.valid && cmd_bus.ready) begin
        advance_ranger(offered);
        words_taken++;
        send_gap = send_idle ? $urandom_range(0, MAX_GAP) : 0;
      end
      if (!cmd_bus.valid || cmd_bus.ready) begin
        if (send_gap > 0) begin
          send_gap--;
          cmd_bus.valid <= 1'b0;
        end else if (pending_words.size() != 0) begin
          offered = pending_words.pop_front();
          cmd_bus.operation  <= offered.op;
          cmd_bus.sensor     <= offered.sensor;
          cmd_bus.echo_level <= offered.level;
          cmd_bus.valid      <= 1'b1;
        end else begin
          cmd_bus.valid <= 1'b0;
        end
      end
    end
  end

  // Result monitor and checker.
  always @(posedge clk) begin
    if (rst) begin
      rsp_bus.ready <= 1'b0;
      recv_gap = 0;
      hold_left = 0;
    end else begin
      if (long_hold_req != 0) begin
        hold_left = long_hold_req;
        long_hold_req <= 0;
      end
      if (rsp_bus.valid && rsp_bus.ready) begin
        seen = '{sensor_id: rsp_bus.sensor_id, pin_fell: rsp_bus.pin_fell,
                 pin_rose: rsp_bus.pin_rose, ready_res: rsp_bus.ready_res,
                 distance: rsp_bus.distance, last: rsp_bus.last};
        if (expected_readings.size() == 0) begin
          report($sformatf("unexpected word for sensor %0d", seen.sensor_id));
        end else begin
          want = expected_readings.pop_front();
          if (seen.sensor_id !== want.sensor_id)
            report($sformatf("sensor_id %0d, expected %0d", seen.sensor_id, want.sensor_id));
          if (seen.pin_fell !== want.pin_fell)
            report($sformatf("sensor %0d pin_fell %b, expected %b",
                             want.sensor_id, seen.pin_fell, want.pin_fell));
          if (seen.pin_rose !== want.pin_rose)
            report($sformatf("sensor %0d pin_rose %b, expected %b",
                             want.sensor_id, seen.pin_rose, want.pin_rose));
          if (seen.ready_res !== want.ready_res)
            report($sformatf("sensor %0d ready_res %b, expected %b",
                             want.sensor_id, seen.ready_res, want.ready_res));
          if (seen.distance !== want.distance)
            report($sformatf("sensor %0d distance %0d, expected %0d",
                             want.sensor_id, seen.distance, want.distance));
          if (seen.last !== want.last)
            report($sformatf("sensor %0d last %b, expected %b",
                             want.sensor_id, seen.last, want.last));
        end
        recv_gap = recv_idle ? $urandom_range(0, MAX_GAP) : 0;
      end
      if (hold_left > 0) begin
        hold_left--;
        rsp_bus.ready <= 1'b0;
      end else if (recv_gap > 0) begin
        recv_gap--;
        rsp_bus.ready <= 1'b0;
      end else begin
        rsp_bus.ready <= 1'b1;
      end
    end
  end

  initial begin
    int unsigned rand_base;
    int unsigned phase_start;
    int unsigned phase_len;
    int unsigned phase_no;
    int unsigned s;
    rst = 1'b1;
    cfg_write = 1'b0;
    cfg_index = '0;
    cfg_data = '0;
    cmd_bus.valid = 1'b0;
    cmd_bus.operation = '0;
    cmd_bus.sensor = '0;
    cmd_bus.echo_level = 1'b0;
    rsp_bus.ready = 1'b0;
    repeat (8) @(posedge clk);
    rst <= 1'b0;

    // Directed: extremes, every operation, edge corner cases.
    write_reg(REG_ENABLE, '1);
    write_reg(REG_PERIOD, 100000);
    write_reg(REG_TRIG, 2);
    write_reg(REG_TIMEOUT, 3);
    write_reg(REG_MAXDIST, '1);
    write_reg(CFG_IDX_W'(int'(REG_MAXDIST) + 1), $urandom);
    queue_op(OP_READ, 0, 1'b0);
    queue_op(OP_READ, 7, 1'b1);
    queue_op(OP_TRIGGER, 0, 1'b1);
    queue_op(OP_TRIGGER, 7, 1'b0);
    queue_ticks(4);                    // both pins fall, then both time out
    queue_op(OP_ECHO, 0, 1'b1);
    queue_ticks(2);
    queue_op(OP_ECHO, 0, 1'b0);        // long enough to keep
    queue_op(OP_ECHO, 3, 1'b0);        // falling with no rising edge
    queue_op(OP_ECHO, 5, 1'b1);
    queue_op(OP_ECHO, 5, 1'b0);        // zero count
    queue_op(OP_ECHO, 6, 1'b1);
    queue_ticks(1);
    queue_op(OP_ECHO, 6, 1'b0);        // below the keep threshold
    queue_op(OP_READ, 0, 1'b0);

    rand_base = words_queued;
    phase_no = 0;
    while (words_queued - rand_base < RANDOM_WORDS) begin
      wait_idle();
      case ($urandom_range(0, 3))
        0:       write_reg(REG_ENABLE, '0);
        1:       write_reg(REG_ENABLE, '1);
        default: write_reg(REG_ENABLE, $urandom);
      endcase
      case ($urandom_range(0, 5))
        0:       write_reg(REG_PERIOD, 1);
        1:       write_reg(REG_PERIOD, '1);
        2:       write_reg(REG_PERIOD, '0);
        default: write_reg(REG_PERIOD, $urandom_range(5000, 100000));
      endcase
      case ($urandom_range(0, 5))
        0:       write_reg(REG_TRIG, '0);
        1:       write_reg(REG_TRIG, '1);
        default: write_reg(REG_TRIG, $urandom_range(1, 4));
      endcase
      case ($urandom_range(0, 5))
        0:       write_reg(REG_TIMEOUT, '0);
        1:       write_reg(REG_TIMEOUT, '1);
        default: write_reg(REG_TIMEOUT, $urandom_range(1, 12));
      endcase
      case ($urandom_range(0, 3))
        0:       write_reg(REG_MAXDIST, '0);
        1:       write_reg(REG_MAXDIST, '1);
        default: write_reg(REG_MAXDIST, $urandom);
      endcase
      if ($urandom_range(0, 1))
        write_reg(CFG_IDX_W'($urandom_range(int'(REG_MAXDIST) + 1, (1 << CFG_IDX_W) - 1)),
                  $urandom);
      send_idle = $urandom_range(0, 2) != 0;
      recv_idle = $urandom_range(0, 2) != 0;
      if (phase_no == 0) begin
        // sender keeps offering while results back up
        send_idle = 1'b0;
        long_hold_req <= LONG_HOLD;
      end
      phase_start = words_queued;
      phase_len = $urandom_range(30, 60);
      while (words_queued - phase_start < phase_len) begin
        if ($urandom_range(0, 3) == 0) begin
          queue_op(op_t'($urandom_range(0, 3)), $urandom_range(0, 7), $urandom_range(0, 1));
        end else begin
          s = $urandom_range(0, SENSOR_COUNT - 1);
          repeat (3) if (!cfg_enable[s]) s = $urandom_range(0, SENSOR_COUNT - 1);
          queue_op(OP_TRIGGER, s, $urandom_range(0, 1));
          queue_ticks($urandom_range(0, 6));
          if ($urandom_range(0, 4) != 0) queue_op(OP_ECHO, s, 1'b1);
          queue_ticks($urandom_range(0, 20));
          queue_op(OP_ECHO, s, 1'b0);
          if ($urandom_range(0, 1)) queue_op(OP_READ, s, $urandom_range(0, 1));
        end
      end
      phase_no++;
    end

    // One long echo at the largest period drives the distance into saturation.
    wait_idle();
    s = $urandom_range(0, SENSOR_COUNT - 1);
    write_reg(REG_ENABLE, '0);
    write_reg(REG_ENABLE, 1 << s);
    write_reg(REG_PERIOD, '1);
    send_idle = 1'b0;
    recv_idle = 1'b0;
    queue_op(OP_ECHO, s, 1'b1);
    queue_ticks(SAT_TICKS);
    queue_op(OP_ECHO, s, 1'b0);
    queue_op(OP_READ, s, 1'b0);

    wait_idle();
    if (expected_readings.size() != 0)
      report($sformatf("%0d results never arrived", expected_readings.size()));
    if (mismatches == 0) begin
      $display("** multi_channel_ultrasonic_ranger: PASSED **");
    end else begin
      $display("** multi_channel_ultrasonic_ranger: FAILED **");
    end
    $finish;
  end

endmodule
